@@ hw/rtl/identifier_string_tokenizer_defines.svh @@
// assertion helpers used by the tokenizer top level
`ifndef IDENTIFIER_STRING_TOKENIZER_DEFINES_SVH
`define IDENTIFIER_STRING_TOKENIZER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define IST_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define IST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ist_pkg.sv @@
package ist_pkg;

  // lexer modes, one-hot
  typedef enum logic [4:0] {
    MODE_START  = 5'b00001,
    MODE_IDENT  = 5'b00010,
    MODE_STRING = 5'b00100,
    MODE_ESCAPE = 5'b01000,
    MODE_END    = 5'b10000
  } mode_t;

  // result kinds
  localparam logic [1:0] KIND_CHAR      = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END = 2'd1;
  localparam logic [1:0] KIND_ERROR     = 2'd2;
  localparam logic [1:0] KIND_EOS       = 2'd3;

  // token types
  localparam logic TYPE_IDENT  = 1'b0;
  localparam logic TYPE_STRING = 1'b1;

  // error codes
  localparam logic ERR_BAD_ESCAPE   = 1'b0;
  localparam logic ERR_UNTERMINATED = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  // one result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic        token_type;
    logic [7:0]  char_value;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] end_line;
    logic [15:0] end_column;
    logic        error_code;
    logic        last;
  } res_t;

  localparam res_t RES_NONE = '0;

endpackage

@@ hw/rtl/identifier_string_tokenizer.sv @@
// results are written into a registered result queue and offered from its head
// throughput: one input byte per cycle while in_stall is low; results leave while out_stall is low
// a byte ending an identifier can give two results; a four-entry result queue
// absorbs them and in_stall rises when fewer than two entries are free
// reset (rst_n low, synchronous): queue emptied, mode between tokens, all positions 1
`include "identifier_string_tokenizer_defines.svh"

module identifier_string_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic        out_token_type,
  output logic [7:0]  out_char_value,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic [15:0] out_end_line,
  output logic [15:0] out_end_column,
  output logic        out_error_code,
  output logic        out_last
);

  localparam int QDEPTH = 4;
  localparam int QIDX   = $clog2(QDEPTH);
  localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};
  localparam logic [QIDX:0] Q_LIMIT = (QIDX+1)'(QDEPTH - 2);
  localparam logic [QIDX:0] Q_FULL  = (QIDX+1)'(QDEPTH);

  // lexer state
  ist_pkg::mode_t           mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [POSITION_BITS-1:0] tok_line_r, tok_line_nxt, tok_col_r, tok_col_nxt;

  ist_pkg::res_t res0, res1;
  logic [1:0]    res_count;

  // result queue
  ist_pkg::res_t   q_r [QDEPTH];
  logic [QIDX-1:0] wr_r, rd_r;
  logic [QIDX:0]   cnt_r, cnt_nxt;

  logic in_acc, out_acc;
  logic [1:0] push_n;
  logic at_end;

  ist_step #(.POSITION_BITS(POSITION_BITS)) u_step (
    .mode         (mode_r),
    .line         (line_r),
    .col          (col_r),
    .tok_line     (tok_line_r),
    .tok_col      (tok_col_r),
    .byte_value   (in_byte_value),
    .end_of_input (in_end_of_input),
    .mode_nxt     (mode_nxt),
    .line_nxt     (line_nxt),
    .col_nxt      (col_nxt),
    .tok_line_nxt (tok_line_nxt),
    .tok_col_nxt  (tok_col_nxt),
    .res0         (res0),
    .res1         (res1),
    .res_count    (res_count)
  );

  // handshakes
  assign in_stall  = (cnt_r > Q_LIMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && !out_stall;
  assign push_n    = in_acc ? res_count : 2'd0;
  assign cnt_nxt   = cnt_r + (QIDX+1)'(push_n) - (QIDX+1)'(out_acc);

  // lexer state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= ist_pkg::MODE_START;
      line_r     <= POS_ONE;
      col_r      <= POS_ONE;
      tok_line_r <= POS_ONE;
      tok_col_r  <= POS_ONE;
    end else if (in_acc) begin
      mode_r     <= mode_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QIDX'(push_n);
      rd_r  <= rd_r + QIDX'(out_acc);
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_r] <= res0;
    if (push_n == 2'd2) q_r[wr_r + QIDX'(1)] <= res1;
  end

  // head of queue drives the result transaction
  ist_pkg::res_t head;
  assign head             = q_r[rd_r];
  assign out_kind         = head.kind;
  assign out_token_type   = head.token_type;
  assign out_char_value   = head.char_value;
  assign out_start_line   = head.start_line;
  assign out_start_column = head.start_column;
  assign out_end_line     = head.end_line;
  assign out_end_column   = head.end_column;
  assign out_error_code   = head.error_code;
  assign out_last         = head.last;

  // checks
  assign at_end = (mode_r == ist_pkg::MODE_END);

  `IST_ASSERT_ALWAYS(a_q_bound, cnt_r <= Q_FULL, "result queue overflow")
  `IST_ASSERT_NEXT(a_end_sticky, at_end, at_end, "left end of stream")
  `IST_ASSERT_NEXT(a_push_shows, push_n != 2'd0, out_valid, "pushed result not offered")

endmodule

@@ hw/rtl/ist_step.sv @@
module ist_step #(
  parameter int POSITION_BITS = 16
) (
  input  ist_pkg::mode_t              mode,
  input  logic [POSITION_BITS-1:0]    line,
  input  logic [POSITION_BITS-1:0]    col,
  input  logic [POSITION_BITS-1:0]    tok_line,
  input  logic [POSITION_BITS-1:0]    tok_col,
  input  logic [7:0]                  byte_value,
  input  logic                        end_of_input,
  output ist_pkg::mode_t              mode_nxt,
  output logic [POSITION_BITS-1:0]    line_nxt,
  output logic [POSITION_BITS-1:0]    col_nxt,
  output logic [POSITION_BITS-1:0]    tok_line_nxt,
  output logic [POSITION_BITS-1:0]    tok_col_nxt,
  output ist_pkg::res_t               res0,
  output ist_pkg::res_t               res1,
  output logic [1:0]                  res_count
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  // low 16 bits of a position, zero extended when positions are narrower
  function automatic logic [15:0] loc16(input logic [POSITION_BITS-1:0] pos);
    logic [POSITION_BITS+15:0] ext;
    ext = {16'b0, pos};
    return ext[15:0];
  endfunction

  // character classes
  logic b_space, b_letter, b_ident, b_esc_ok;
  logic [7:0] esc_val;

  always_comb begin
    b_space  = (byte_value == ist_pkg::CH_SPACE) ||
               (byte_value >= ist_pkg::CH_HT && byte_value <= ist_pkg::CH_CR);
    b_letter = (byte_value >= 8'h61 && byte_value <= 8'h7A) ||
               (byte_value >= 8'h41 && byte_value <= 8'h5A) ||
               (byte_value == ist_pkg::CH_US);
    b_ident  = b_letter || (byte_value >= 8'h30 && byte_value <= 8'h39);
    b_esc_ok = 1'b1;
    case (byte_value)
      ist_pkg::CH_B:      esc_val = ist_pkg::CH_BS;
      ist_pkg::CH_T:      esc_val = ist_pkg::CH_HT;
      ist_pkg::CH_N:      esc_val = ist_pkg::CH_NL;
      ist_pkg::CH_V:      esc_val = ist_pkg::CH_VT;
      ist_pkg::CH_F:      esc_val = ist_pkg::CH_FF;
      ist_pkg::CH_R:      esc_val = ist_pkg::CH_CR;
      ist_pkg::CH_QUOTE:  esc_val = ist_pkg::CH_QUOTE;
      ist_pkg::CH_BSLASH: esc_val = ist_pkg::CH_BSLASH;
      default: begin
        esc_val  = 8'h00;
        b_esc_ok = 1'b0;
      end
    endcase
  end

  // position after consuming this byte, saturating
  logic [POSITION_BITS-1:0] adv_line, adv_col;

  always_comb begin
    adv_line = line;
    adv_col  = col;
    if (byte_value == ist_pkg::CH_NL) begin
      if (line != POS_MAX) adv_line = line + POS_ONE;
      adv_col = POS_ONE;
    end else if (byte_value != ist_pkg::CH_CR) begin
      if (col != POS_MAX) adv_col = col + POS_ONE;
    end
  end

  // between-token handling, shared by start mode and identifier end
  ist_pkg::mode_t bt_mode;
  ist_pkg::res_t  bt_res;
  logic           bt_valid, bt_adv, bt_mark;

  always_comb begin
    bt_mode  = ist_pkg::MODE_START;
    bt_res   = ist_pkg::RES_NONE;
    bt_valid = 1'b0;
    bt_adv   = 1'b0;
    bt_mark  = 1'b0;
    if (end_of_input) begin
      bt_mode       = ist_pkg::MODE_END;
      bt_res.kind   = ist_pkg::KIND_EOS;
      bt_valid      = 1'b1;
    end else if (b_space) begin
      bt_adv = 1'b1;
    end else if (b_letter) begin
      bt_mark           = 1'b1;
      bt_adv            = 1'b1;
      bt_mode           = ist_pkg::MODE_IDENT;
      bt_res.kind       = ist_pkg::KIND_CHAR;
      bt_res.token_type = ist_pkg::TYPE_IDENT;
      bt_res.char_value = byte_value;
      bt_valid          = 1'b1;
    end else if (byte_value == ist_pkg::CH_QUOTE) begin
      bt_mark = 1'b1;
      bt_adv  = 1'b1;
      bt_mode = ist_pkg::MODE_STRING;
    end else begin
      bt_mode     = ist_pkg::MODE_END;
      bt_res.kind = ist_pkg::KIND_EOS;
      bt_valid    = 1'b1;
    end
  end

  // per-mode update
  logic adv, mark;

  always_comb begin
    mode_nxt  = mode;
    res0      = ist_pkg::RES_NONE;
    res1      = ist_pkg::RES_NONE;
    res_count = 2'd0;
    adv       = 1'b0;
    mark      = 1'b0;
    case (mode)
      ist_pkg::MODE_START: begin
        mode_nxt  = bt_mode;
        res0      = bt_res;
        res_count = {1'b0, bt_valid};
        adv       = bt_adv;
        mark      = bt_mark;
      end
      ist_pkg::MODE_IDENT: begin
        if (!end_of_input && b_ident) begin
          res0.kind       = ist_pkg::KIND_CHAR;
          res0.token_type = ist_pkg::TYPE_IDENT;
          res0.char_value = byte_value;
          res_count       = 2'd1;
          adv             = 1'b1;
        end else begin
          // token end uses the location before the terminating byte
          res0.kind         = ist_pkg::KIND_TOKEN_END;
          res0.token_type   = ist_pkg::TYPE_IDENT;
          res0.start_line   = loc16(tok_line);
          res0.start_column = loc16(tok_col);
          res0.end_line     = loc16(line);
          res0.end_column   = loc16(col);
          res1              = bt_res;
          res_count         = bt_valid ? 2'd2 : 2'd1;
          mode_nxt          = bt_mode;
          adv               = bt_adv;
          mark              = bt_mark;
        end
      end
      ist_pkg::MODE_STRING: begin
        if (end_of_input) begin
          mode_nxt        = ist_pkg::MODE_END;
          res0.kind       = ist_pkg::KIND_ERROR;
          res0.error_code = ist_pkg::ERR_UNTERMINATED;
          res_count       = 2'd1;
        end else if (byte_value == ist_pkg::CH_QUOTE) begin
          // end location is just past the closing quote
          adv               = 1'b1;
          mode_nxt          = ist_pkg::MODE_START;
          res0.kind         = ist_pkg::KIND_TOKEN_END;
          res0.token_type   = ist_pkg::TYPE_STRING;
          res0.start_line   = loc16(tok_line);
          res0.start_column = loc16(tok_col);
          res0.end_line     = loc16(adv_line);
          res0.end_column   = loc16(adv_col);
          res_count         = 2'd1;
        end else if (byte_value == ist_pkg::CH_BSLASH) begin
          adv      = 1'b1;
          mode_nxt = ist_pkg::MODE_ESCAPE;
        end else begin
          adv             = 1'b1;
          res0.kind       = ist_pkg::KIND_CHAR;
          res0.token_type = ist_pkg::TYPE_STRING;
          res0.char_value = byte_value;
          res_count       = 2'd1;
        end
      end
      ist_pkg::MODE_ESCAPE: begin
        if (end_of_input || !b_esc_ok) begin
          mode_nxt        = ist_pkg::MODE_END;
          res0.kind       = ist_pkg::KIND_ERROR;
          res0.error_code = ist_pkg::ERR_BAD_ESCAPE;
          res_count       = 2'd1;
        end else begin
          adv             = 1'b1;
          mode_nxt        = ist_pkg::MODE_STRING;
          res0.kind       = ist_pkg::KIND_CHAR;
          res0.token_type = ist_pkg::TYPE_STRING;
          res0.char_value = esc_val;
          res_count       = 2'd1;
        end
      end
      default: begin
        mode_nxt = ist_pkg::MODE_END;
      end
    endcase
    res0.last = (res_count == 2'd1);
    res1.last = 1'b1;
  end

  // position and token start updates
  assign line_nxt     = adv  ? adv_line : line;
  assign col_nxt      = adv  ? adv_col  : col;
  assign tok_line_nxt = mark ? line     : tok_line;
  assign tok_col_nxt  = mark ? col      : tok_col;

endmodule
